FILE: hw/rtl/cdq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes for the circular deque: operation codes, result
// status codes and the element width.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic [1:0] {
        FN_PUSH_FRONT = 2'd0,
        FN_POP_FRONT  = 2'd1,
        FN_PUSH_REAR  = 2'd2,
        FN_POP_REAR   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

endpackage

FILE: hw/rtl/cdq_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_mem
// Element store of the deque: one write port and one read port, read data
// registered and held until the next read.
// ----------------------------------------------------------------------------
module cdq_mem
    import cdq_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned PTR_W = 4
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [PTR_W-1:0]         wr_addr,
    input  logic signed [DATA_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [PTR_W-1:0]         rd_addr,
    output logic signed [DATA_W-1:0] rd_data
);

    logic signed [DATA_W-1:0] slots_mem [DEPTH];
    logic signed [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= slots_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/cdq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdq_ctrl
// Front and rear pointers and the empty mark. Decodes each accepted item,
// checks full and empty, moves or resets pointers and issues store access.
// ----------------------------------------------------------------------------
module cdq_ctrl
    import cdq_pkg::*;
#(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned PTR_W = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [1:0]               func,
    input  logic signed [DATA_W-1:0] push_value,
    output logic                     wr_en,
    output logic [PTR_W-1:0]         wr_addr,
    output logic signed [DATA_W-1:0] wr_data,
    output logic                     rd_en,
    output logic [PTR_W-1:0]         rd_addr,
    output status_t                  status,
    output logic                     pop_ok
);

    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic             empty_reg, empty_next;

    logic [PTR_W-1:0] head_dec;
    logic [PTR_W-1:0] head_inc;
    logic [PTR_W-1:0] tail_dec;
    logic [PTR_W-1:0] tail_inc;
    logic             full;
    func_t            fn;

    assign fn       = func_t'(func);
    assign head_dec = (head_reg == '0) ? LAST : head_reg - 1'b1;
    assign head_inc = (head_reg == LAST) ? '0 : head_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST : tail_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST) ? '0 : tail_reg + 1'b1;
    assign full     = !empty_reg && (tail_inc == head_reg);
    assign wr_data  = push_value;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        empty_next = empty_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        rd_en      = 1'b0;
        rd_addr    = head_reg;
        status     = ST_DONE;
        pop_ok     = 1'b0;
        if (accept)
        begin
            unique case (fn)
                FN_PUSH_FRONT, FN_PUSH_REAR:
                begin
                    if (empty_reg)
                    begin
                        head_next  = '0;
                        tail_next  = '0;
                        empty_next = 1'b0;
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                    end
                    else if (full)
                    begin
                        status = ST_FULL;
                    end
                    else if (fn == FN_PUSH_FRONT)
                    begin
                        head_next = head_dec;
                        wr_en     = 1'b1;
                        wr_addr   = head_dec;
                    end
                    else
                    begin
                        tail_next = tail_inc;
                        wr_en     = 1'b1;
                        wr_addr   = tail_inc;
                    end
                end
                FN_POP_FRONT, FN_POP_REAR:
                begin
                    if (empty_reg)
                    begin
                        status = ST_EMPTY;
                    end
                    else
                    begin
                        rd_en   = 1'b1;
                        pop_ok  = 1'b1;
                        rd_addr = (fn == FN_POP_FRONT) ? head_reg : tail_reg;
                        if (head_reg == tail_reg)
                        begin
                            head_next  = '0;
                            tail_next  = '0;
                            empty_next = 1'b1;
                        end
                        else if (fn == FN_POP_FRONT)
                        begin
                            head_next = head_inc;
                        end
                        else
                        begin
                            tail_next = tail_dec;
                        end
                    end
                end
                default:
                begin
                    status = ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            empty_reg <= empty_next;
        end
    end

endmodule

FILE: hw/rtl/circular_deque.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed 32-bit elements in a circular store, with
// push and pop at either end and a status for every item.
//
//  channel  signals                          direction  content
//  in       in_valid, in_ready               into       func, push_value
//  out      out_valid, out_ready             out of     pop_value, status
//
//  one item per cycle while results are taken; the result appears in the
//  cycle after acceptance, when the store's registered read data is available
//  reset clears the pointers and marks the queue empty; the store itself
//  is not cleared and an entry is read only after it was written
//  a held result stalls input unless out_ready takes it in the same cycle
// ----------------------------------------------------------------------------
module circular_deque
    import cdq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               func,
    input  logic signed [DATA_W-1:0] push_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [DATA_W-1:0] pop_value,
    output logic [1:0]               status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                     accept;
    logic                     wr_en;
    logic [PTR_W-1:0]         wr_addr;
    logic signed [DATA_W-1:0] wr_data;
    logic                     rd_en;
    logic [PTR_W-1:0]         rd_addr;
    logic signed [DATA_W-1:0] rd_data;
    status_t                  step_status;
    logic                     step_pop_ok;

    logic    out_valid_reg, out_valid_next;
    status_t status_reg, status_next;
    logic    pop_ok_reg, pop_ok_next;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    cdq_ctrl #(
        .DEPTH (DEPTH),
        .PTR_W (PTR_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .func       (func),
        .push_value (push_value),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .status     (step_status),
        .pop_ok     (step_pop_ok)
    );

    cdq_mem #(
        .DEPTH (DEPTH),
        .PTR_W (PTR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // result stage
    always_comb
    begin
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        pop_ok_next    = pop_ok_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            status_next    = step_status;
            pop_ok_next    = step_pop_ok;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        pop_ok_reg <= pop_ok_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign pop_value = pop_ok_reg ? rd_data : '0;

endmodule

FILE: test/circular_deque_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_tb
// Self-checking bench for the circular deque. A short table of directed
// items covers the empty and full edges, the extreme element values and
// every operation. A long random run follows, moving in phases that lean
// toward filling, draining or neither. Typed rows are checked against the
// table, the rest a shadow deque. Random stalls are applied on both sides.
// ----------------------------------------------------------------------------
module circular_deque_tb;

    import cdq_pkg::*;

    localparam int unsigned DEPTH        = 16;
    localparam int unsigned IDX_W        = $clog2(DEPTH);
    localparam int          RANDOM_ITEMS = 1300;
    localparam int          CALM_ITEMS   = 200;
    localparam int          CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [DATA_W-1:0] pop_value;
        status_t           status;
    } deque_result_t;

    typedef struct {
        func_t             op;
        logic [DATA_W-1:0] value;
        bit                typed;
        deque_result_t     result;
    } stim_row_t;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     in_ready;
    logic [1:0]               func       = FN_PUSH_FRONT;
    logic signed [DATA_W-1:0] push_value = '0;
    logic                     out_valid;
    logic                     out_ready  = 1'b0;
    logic signed [DATA_W-1:0] pop_value;
    logic [1:0]               status;

    // shadow deque
    logic [DATA_W-1:0] shadow_slots [DEPTH];
    logic [IDX_W-1:0]  front_idx    = '0;
    logic [IDX_W-1:0]  rear_idx     = '0;
    bit                shadow_empty = 1'b1;

    deque_result_t pending_results [$];
    stim_row_t     stim_table [$];
    int            error_count  = 0;
    int            cycle_count  = 0;
    int            stall_left   = 0;
    bit            idle_on      = 1'b0;

    circular_deque #(
        .DEPTH      (DEPTH)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pop_value  (pop_value),
        .status     (status)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("circular_deque test failed");
            $finish;
        end
    end

    function automatic logic [IDX_W-1:0] next_idx(logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] prev_idx(logic [IDX_W-1:0] idx);
        return (idx == '0) ? IDX_W'(DEPTH - 1) : idx - 1'b1;
    endfunction

    function automatic deque_result_t apply_deque_op(func_t op, logic [DATA_W-1:0] value);
        deque_result_t r;
        r.pop_value = '0;
        r.status    = ST_DONE;
        if (op == FN_PUSH_FRONT || op == FN_PUSH_REAR)
        begin
            if (shadow_empty)
            begin
                front_idx       = '0;
                rear_idx        = '0;
                shadow_slots[0] = value;
                shadow_empty    = 1'b0;
            end
            else if (next_idx(rear_idx) == front_idx)
                r.status = ST_FULL;
            else if (op == FN_PUSH_FRONT)
            begin
                front_idx               = prev_idx(front_idx);
                shadow_slots[front_idx] = value;
            end
            else
            begin
                rear_idx               = next_idx(rear_idx);
                shadow_slots[rear_idx] = value;
            end
        end
        else if (shadow_empty)
            r.status = ST_EMPTY;
        else
        begin
            r.pop_value = (op == FN_POP_FRONT) ? shadow_slots[front_idx] : shadow_slots[rear_idx];
            if (front_idx == rear_idx)
            begin
                shadow_empty = 1'b1;
                front_idx    = '0;
                rear_idx     = '0;
            end
            else if (op == FN_POP_FRONT)
                front_idx = next_idx(front_idx);
            else
                rear_idx = prev_idx(rear_idx);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                   logic [DATA_W-1:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic add_row(func_t op, logic [DATA_W-1:0] value, bit typed,
                           logic [DATA_W-1:0] want_pop, status_t want_status);
        stim_row_t row;
        row.op               = op;
        row.value            = value;
        row.typed            = typed;
        row.result.pop_value = want_pop;
        row.result.status    = want_status;
        stim_table.push_back(row);
    endtask

    // called at a rising edge; returns at the edge where the item is taken
    task automatic send_item(func_t op, logic [DATA_W-1:0] value, bit typed,
                             deque_result_t typed_result);
        deque_result_t predicted;
        in_valid   <= 1'b1;
        func       <= op;
        push_value <= value;
        forever
        begin
            @(negedge clk);
            if (in_ready)
                break;
            @(posedge clk);
        end
        predicted = apply_deque_op(op, value);
        pending_results.push_back(typed ? typed_result : predicted);
        @(posedge clk);
    endtask

    task automatic sender_gap();
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 16);
        end
        else
            out_ready <= 1'b1;
    end

    always @(negedge clk)
    begin
        deque_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", pop_value, '0);
            else
            begin
                want = pending_results.pop_front();
                if (pop_value !== want.pop_value)
                    report_mismatch("pop_value", pop_value, want.pop_value);
                if (status !== want.status)
                    report_mismatch("status", DATA_W'(status), DATA_W'(want.status));
            end
        end
    end

    initial
    begin
        int            push_weight;
        int            phase_left;
        func_t         op;
        logic [31:0]   value;
        deque_result_t no_result;

        no_result  = '0;
        phase_left = 0;
        push_weight = 50;

        // empty after reset, extremes, last-element pop, fill to full
        add_row(FN_POP_FRONT,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY);
        add_row(FN_POP_REAR,   32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_EMPTY);
        add_row(FN_PUSH_REAR,  32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_DONE);
        add_row(FN_PUSH_FRONT, 32'h8000_0000, 1'b1, 32'h0000_0000, ST_DONE);
        add_row(FN_POP_FRONT,  32'h1234_5678, 1'b1, 32'h8000_0000, ST_DONE);
        add_row(FN_POP_REAR,   32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF, ST_DONE);
        add_row(FN_POP_REAR,   32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY);
        add_row(FN_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_DONE);
        for (int i = 0; i < DEPTH - 1; i++)
            add_row((i % 2) ? FN_PUSH_FRONT : FN_PUSH_REAR,
                    (i % 2) ? 32'hAAAA_AAAA ^ i : 32'h5555_5555 ^ (i << 24),
                    1'b0, '0, ST_DONE);
        add_row(FN_PUSH_REAR,  32'h1234_5678, 1'b1, 32'h0000_0000, ST_FULL);
        add_row(FN_PUSH_FRONT, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_FULL);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_on = 1'b1;
        foreach (stim_table[i])
        begin
            sender_gap();
            send_item(stim_table[i].op, stim_table[i].value, stim_table[i].typed,
                      stim_table[i].result);
        end

        // hold off until the deque has answered everything
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (phase_left == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       push_weight = 85;
                    1:       push_weight = 15;
                    default: push_weight = 50;
                endcase
                phase_left = $urandom_range(10, 60);
                idle_on    = ($urandom_range(0, 3) != 0);
            end
            phase_left--;
            if (n >= RANDOM_ITEMS - CALM_ITEMS)
                idle_on = 1'b0;

            if ($urandom_range(0, 99) < push_weight)
                op = $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_REAR;
            else
                op = $urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_REAR;

            case ($urandom_range(0, 7))
                0:       value = 32'h8000_0000;
                1:       value = 32'h7FFF_FFFF;
                2:       value = 32'h0000_0000;
                3:       value = 32'hFFFF_FFFF;
                default: value = $urandom;
            endcase

            sender_gap();
            send_item(op, value, 1'b0, no_result);
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("circular_deque test passed");
        else
            $display("circular_deque test failed");
        $finish;
    end

endmodule
